FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ohi_pkg.sv
// ----------------------------------------------------------------------------
// ohi_pkg
// Types and constants of the open-addressing hash insert block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ohi_pkg;

  localparam int SLOT_W        = 6;
  localparam int VALUE_FIELD_W = 16;
  localparam int SIZE_W        = 7;
  localparam int STEP_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 7;
  localparam int STEP_MODULUS  = 5;
  localparam int STEP_MAX      = 5;

  localparam logic [STEP_W-1:0]      STEP_OFFSET      = 3'd1;
  localparam logic [SIZE_W-1:0]      TABLE_SIZE_RESET = 7'd64;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SIZE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_MODE   = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_KEY = 2'd2
  } status_t;

  typedef struct packed {
    logic [SLOT_W-1:0]        home_slot;
    logic [VALUE_FIELD_W-1:0] item_value;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] placed_slot;
  } result_t;

endpackage

FILE: sv/ohi_step.sv
// ----------------------------------------------------------------------------
// ohi_step
// Probe step: 1 in linear mode, (value mod 5) + 1 in double-hash mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohi_step (
  input  logic [ohi_pkg::VALUE_FIELD_W-1:0] value,
  input  logic                              probe_mode,
  output logic [ohi_pkg::STEP_W-1:0]        step
);

  localparam int NIBBLES = ohi_pkg::VALUE_FIELD_W / 4;

  logic [5:0] rem;

  // 16 = 1 mod 5, so the nibble sum keeps the residue
  always_comb begin
    rem = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      rem = rem + 6'(value[4*i +: 4]);
    end
    for (int k = 3; k >= 0; k--) begin
      if (rem >= 6'(ohi_pkg::STEP_MODULUS << k)) begin
        rem = rem - 6'(ohi_pkg::STEP_MODULUS << k);
      end
    end
    if (probe_mode) begin
      step = 3'(rem) + ohi_pkg::STEP_OFFSET;
    end else begin
      step = ohi_pkg::STEP_OFFSET;
    end
  end

endmodule

FILE: sv/ohi_table.sv
// ----------------------------------------------------------------------------
// ohi_table
// Slot occupancy and value memories, with a clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohi_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic                           rd_taken,
  input  logic                           wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  logic [VALUE_WIDTH-1:0]         wr_value,
  output logic                           clearing
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic                   valid_mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] value_mem [TABLE_DEPTH];
  logic [ADDR_W-1:0]      clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      valid_mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      valid_mem[wr_addr] <= 1'b1;
    end
    rd_taken <= valid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[wr_addr] <= wr_value;
    end
  end

endmodule

FILE: sv/open_addressing_hash_insert.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_insert
// Inserts values into an open-addressing table with linear or double-hash
// probing; one result per item.
// ----------------------------------------------------------------------------
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------
// item in  | start, busy           | item (home_slot, item_value)
// result   | result_valid strobe   | result (status, placed_slot)
// config   | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// Key out of range: result in the cycle after the transfer, busy stays low.
// Otherwise at most as many probes as the table size in use, one read of
// the occupancy memory per cycle; busy drops in the cycle of the result.
// After reset a clearing pass over the table holds busy high;
// config writes are taken throughout. Results cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module open_addressing_hash_insert #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  ohi_pkg::item_t                     item,
  output logic                               result_valid,
  output ohi_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ohi_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ohi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ADDR_W     = $clog2(TABLE_DEPTH);
  localparam int SW         = ohi_pkg::SIZE_W;
  localparam int SW1        = SW + 1;
  localparam int EXT_W      = ADDR_W + SW;
  localparam int SIZE_CAP_I = (TABLE_DEPTH > (1 << SW) - 1) ? (1 << SW) - 1 : TABLE_DEPTH;
  localparam logic [SW-1:0] SIZE_CAP = SW'(SIZE_CAP_I);
  localparam logic [ohi_pkg::VALUE_FIELD_W-1:0] VMASK =
    (VALUE_WIDTH >= ohi_pkg::VALUE_FIELD_W) ? {ohi_pkg::VALUE_FIELD_W{1'b1}} :
    ohi_pkg::VALUE_FIELD_W'((64'd1 << VALUE_WIDTH) - 64'd1);

  typedef enum logic [0:0] {
    S_IDLE,
    S_PROBE
  } state_t;

  state_t                             state;
  logic [SW-1:0]                      table_size;
  logic                               probe_mode;
  logic [SW-1:0]                      pos;
  logic [SW-1:0]                      tries;
  logic [ohi_pkg::STEP_W-1:0]         step;
  logic [VALUE_WIDTH-1:0]             value;

  logic [SW-1:0]                      eff_size;
  logic                               bad_key;
  logic                               accept;
  logic [ohi_pkg::VALUE_FIELD_W-1:0]  item_masked;
  logic [ohi_pkg::STEP_W-1:0]         step_new;
  logic [SW:0]                        wrap;
  logic [SW-1:0]                      pos_next;
  logic [SW-1:0]                      rd_pos;
  logic [EXT_W-1:0]                   rd_ext;
  logic [EXT_W-1:0]                   wr_ext;
  logic                               slot_taken;
  logic                               wr_en;
  logic                               clearing;

  assign cfg_ready   = 1'b1;
  assign item_masked = item.item_value & VMASK;
  assign accept      = start && !busy;
  assign busy        = (state != S_IDLE) || clearing;

  always_comb begin
    if (table_size == '0) begin
      eff_size = SW'(1);
    end else if (table_size > SIZE_CAP) begin
      eff_size = SIZE_CAP;
    end else begin
      eff_size = table_size;
    end
  end

  assign bad_key = SW'(item.home_slot) >= eff_size;

  // pos < size and step <= 5, so a few conditional subtracts wrap it
  always_comb begin
    wrap = {1'b0, pos} + SW1'(step);
    for (int i = 0; i < ohi_pkg::STEP_MAX; i++) begin
      if (wrap >= {1'b0, eff_size}) begin
        wrap = wrap - {1'b0, eff_size};
      end
    end
    pos_next = wrap[SW-1:0];
  end

  assign rd_pos = (state == S_PROBE) ? pos_next : SW'(item.home_slot);
  assign rd_ext = EXT_W'(rd_pos);
  assign wr_ext = EXT_W'(pos);
  assign wr_en  = (state == S_PROBE) && !slot_taken;

  ohi_step u_step (
    .value      (item_masked),
    .probe_mode (probe_mode),
    .step       (step_new)
  );

  ohi_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_ext[ADDR_W-1:0]),
    .rd_taken (slot_taken),
    .wr_en    (wr_en),
    .wr_addr  (wr_ext[ADDR_W-1:0]),
    .wr_value (value),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      table_size   <= ohi_pkg::TABLE_SIZE_RESET;
      probe_mode   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ohi_pkg::CFG_TABLE_SIZE: table_size <= cfg_data;
          ohi_pkg::CFG_PROBE_MODE: probe_mode <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept && bad_key) begin
            result_valid       <= 1'b1;
            result.status      <= ohi_pkg::ST_BAD_KEY;
            result.placed_slot <= '0;
          end else begin
            result_valid <= 1'b0;
            if (accept) begin
              pos   <= SW'(item.home_slot);
              tries <= eff_size;
              step  <= step_new;
              value <= VALUE_WIDTH'(item_masked);
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (!slot_taken) begin
            result_valid       <= 1'b1;
            result.status      <= ohi_pkg::ST_PLACED;
            result.placed_slot <= pos[ohi_pkg::SLOT_W-1:0];
            state              <= S_IDLE;
          end else if (tries == SW'(1)) begin
            result_valid       <= 1'b1;
            result.status      <= ohi_pkg::ST_FULL;
            result.placed_slot <= '0;
            state              <= S_IDLE;
          end else begin
            result_valid <= 1'b0;
            tries        <= tries - SW'(1);
            pos          <= pos_next;
          end
        end
        default: begin
          result_valid <= 1'b0;
          state        <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/ohi_checker.sv
// ----------------------------------------------------------------------------
// ohi_checker
// Port-level checks of the hash insert block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ohi_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_valid,
  input ohi_pkg::result_t result
);

  `ASSERT_SAME(a_slot_zero_unplaced, result_valid && (result.status != ohi_pkg::ST_PLACED), result.placed_slot == '0, "placed_slot nonzero on unplaced result")
  `ASSERT_NEXT(a_transfer_progress, start && !busy, result_valid || busy, "transfer neither answered nor in progress")
  `ASSERT_SAME(a_result_has_cause, result_valid, $past(busy) || $past(start), "result without a prior transfer")

endmodule

bind open_addressing_hash_insert ohi_checker u_ohi_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
